// ===== rtl/core/ilid_pkg.sv =====
// Shared constants, codes and types for the indexed list block.
package ilid_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_READ     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INS_AT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/indexed_list_insert_delete.sv =====
// Top level: position-addressed ordered list of signed 32-bit values.
//
//   channel  dir  tdata (low bit up)                         tuser
//   s_axis   in   index[6:0], value[38:7], pad to 40         kind[2:0]
//   m_axis   out  read_value[31:0], status[33:32],           -
//                 count[40:34], pad to 48
//
// A read goes via S_RD_WAIT and a refused or ignored operation to S_DONE;
// an insert or delete steps S_SH_RD, S_SH_WR per element moved by one place,
// and an insert ends in S_INS_WR. Each moved element costs one RAM read and
// one RAM write through the single shared pointer step and compare.
// Reset (rst, synchronous) empties the list; the element RAM is not cleared.
// A finished result waits in the output register while the next beat is
// accepted; the sequencer holds in S_DONE only if that register is still full.
module indexed_list_insert_delete #(
  parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // index[6:0], value[38:7]
  input  logic [2:0]  s_axis_tuser,   // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // read_value[31:0], status[33:32], count[40:34]
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > ilid_pkg::INDEX_W) ? CW : ilid_pkg::INDEX_W;

  // Input fields.
  logic [ilid_pkg::KIND_W-1:0]  in_kind;
  logic [ilid_pkg::INDEX_W-1:0] in_index;
  logic [ilid_pkg::VALUE_W-1:0] in_value;

  assign in_kind  = s_axis_tuser;
  assign in_index = s_axis_tdata[ilid_pkg::INDEX_W-1:0];
  assign in_value = s_axis_tdata[ilid_pkg::INDEX_W +: ilid_pkg::VALUE_W];

  // Sequencer and datapath registers.
  ilid_pkg::state_t state, state_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    ptr;       // destination slot of the next move
  logic [CW-1:0]    end_ptr;   // slot where the moves stop
  logic             dir_up;    // delete moves elements down from higher slots
  logic [ilid_pkg::VALUE_W-1:0] value_r;
  logic [ilid_pkg::VALUE_W-1:0] res_rv;
  ilid_pkg::status_t            res_st;

  // Output register.
  logic [ilid_pkg::VALUE_W-1:0] out_rv;
  ilid_pkg::status_t            out_st;
  logic [ilid_pkg::COUNT_W-1:0] out_cnt;

  // RAM port.
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ilid_pkg::VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [ilid_pkg::VALUE_W-1:0] ram_rdata;

  ilid_ram #(
    .WIDTH(ilid_pkg::VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Decode of the incoming beat.
  logic          accept;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] cnt_x;
  logic          is_read, is_ins, is_del;
  logic          rd_ok, ins_range, ins_full, ins_go, del_ok;
  logic [CW-1:0] ins_pos;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign idx_x  = XW'(in_index);
  assign cnt_x  = XW'(count);

  always_comb begin
    is_read = (in_kind == ilid_pkg::KIND_READ);
    is_del  = (in_kind == ilid_pkg::KIND_DELETE);
    is_ins  = (in_kind == ilid_pkg::KIND_INS_HEAD) || (in_kind == ilid_pkg::KIND_INS_TAIL) ||
              (in_kind == ilid_pkg::KIND_INS_AT);
    case (in_kind)
      ilid_pkg::KIND_INS_HEAD: ins_pos = '0;
      ilid_pkg::KIND_INS_TAIL: ins_pos = count;
      default:                 ins_pos = CW'(idx_x);
    endcase
    rd_ok     = idx_x < cnt_x;
    ins_range = (in_kind == ilid_pkg::KIND_INS_AT) && (idx_x > cnt_x);
    ins_full  = (count == CW'(CAPACITY));
    ins_go    = is_ins && !ins_range && !ins_full;
    del_ok    = idx_x < cnt_x;
  end

  // Shared pointer step and stop compare.
  logic [CW-1:0] src_ptr;
  logic          at_end;

  assign src_ptr = dir_up ? (ptr + CW'(1)) : (ptr - CW'(1));
  assign at_end  = (ptr == end_ptr);

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ilid_pkg::S_IDLE: begin
        if (accept) begin
          if (is_read && rd_ok) begin
            state_next = ilid_pkg::S_RD_WAIT;
          end else if (ins_go || (is_del && del_ok)) begin
            state_next = ilid_pkg::S_SH_RD;
          end else begin
            state_next = ilid_pkg::S_DONE;
          end
        end
      end
      ilid_pkg::S_RD_WAIT: state_next = ilid_pkg::S_DONE;
      ilid_pkg::S_SH_RD: begin
        if (at_end) begin
          state_next = dir_up ? ilid_pkg::S_DONE : ilid_pkg::S_INS_WR;
        end else begin
          state_next = ilid_pkg::S_SH_WR;
        end
      end
      ilid_pkg::S_SH_WR:  state_next = ilid_pkg::S_SH_RD;
      ilid_pkg::S_INS_WR: state_next = ilid_pkg::S_DONE;
      ilid_pkg::S_DONE: begin
        if (out_free) begin
          state_next = ilid_pkg::S_IDLE;
        end
      end
      default: state_next = ilid_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: RAM controls and input ready.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = AW'(ptr);
    ram_wdata     = ram_rdata;
    ram_raddr     = AW'(src_ptr);
    case (state)
      ilid_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        ram_raddr     = AW'(in_index);
      end
      ilid_pkg::S_SH_WR: begin
        ram_we = 1'b1;
      end
      ilid_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(end_ptr);
        ram_wdata = value_r;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ilid_pkg::S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // Drop the count once the delete moves are done; bump it on the insert write.
      if (state == ilid_pkg::S_SH_RD && at_end && dir_up) begin
        count <= count - CW'(1);
      end else if (state == ilid_pkg::S_INS_WR) begin
        count <= count + CW'(1);
      end
      if (state == ilid_pkg::S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ilid_pkg::S_IDLE: begin
        if (accept) begin
          value_r <= in_value;
          res_rv  <= '0;
          res_st  <= ilid_pkg::ST_DONE;
          if (is_read) begin
            if (!rd_ok) begin
              res_rv <= '1;
              res_st <= ilid_pkg::ST_RANGE;
            end
          end else if (is_ins) begin
            if (ins_range) begin
              res_st <= ilid_pkg::ST_RANGE;
            end else if (ins_full) begin
              res_st <= ilid_pkg::ST_FULL;
            end
            // Move elements up from the tail until the insert slot is open.
            ptr     <= count;
            end_ptr <= ins_pos;
            dir_up  <= 1'b0;
          end else if (is_del) begin
            if (!del_ok) begin
              res_st <= ilid_pkg::ST_RANGE;
            end
            // Move elements down from above the deleted slot to the tail.
            ptr     <= CW'(idx_x);
            end_ptr <= count - CW'(1);
            dir_up  <= 1'b1;
          end
        end
      end
      ilid_pkg::S_RD_WAIT: res_rv <= ram_rdata;
      ilid_pkg::S_SH_WR:   ptr    <= src_ptr;
      ilid_pkg::S_DONE: begin
        if (out_free) begin
          out_rv  <= res_rv;
          out_st  <= res_st;
          out_cnt <= ilid_pkg::COUNT_W'(count);
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {7'b0, out_cnt, out_st, out_rv};

endmodule

// ===== rtl/core/ilid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ilid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
